### sv/ssstat_pkg.sv
// Shared constants and types for the sample set statistics block.
package ssstat_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int COUNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SHIFT_W  = COUNT_W - 1;
    localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int MEDIAN_W = SAMPLE_BITS + 1;
    localparam int STEP_W   = $clog2(SUM_W + 1);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [SUM_W-1:0]       sum_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } ssstat_cell_ctrl_t;

endpackage

### sv/sample_set_statistics_core.sv
// Top level of the sample set statistics block: sorting chain, running totals, result stage.
//
// The input channel (s_valid, s_ready, s_sample, s_last) takes one sample word per
// cycle while the block is loading a set. Each word is inserted into a sorted chain
// of MAX_SAMPLES cells in the cycle it is accepted, and the running minimum, maximum
// and sum are updated alongside. Words arriving once the chain is full are dropped
// and the overflow flag is raised for the set.
// After the word marked with s_last, s_ready falls while the mean is formed by a
// bit-serial divider and the chain shifts towards its head until the middle
// sample sits in the first cell, or for an even count the two middle samples sit
// in the first two cells (up to n/2 shifts). The result appears on the m_ channel
// once both the divider and the shifting are done, the later of the two deciding.
// The result sits in an output register: loading of the next set begins at once,
// and if that set finishes while the receiver still stalls, the block waits with
// s_ready low until m_ready takes the pending word.
// Synchronous active-low reset empties the set, drops any pending result and
// leaves the block ready for a new set; sample cells need no clearing.
module sample_set_statistics_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ssstat_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ssstat_pkg::SAMPLE_BITS-1:0] m_minimum,
    output logic [ssstat_pkg::SAMPLE_BITS-1:0] m_maximum,
    output logic [ssstat_pkg::SAMPLE_BITS-1:0] m_mean,
    output logic [ssstat_pkg::MEDIAN_W-1:0]    m_median_doubled,
    output logic [ssstat_pkg::COUNT_W-1:0]     m_sample_count,
    output logic                          m_overflow
);
    import ssstat_pkg::*;

    localparam logic S_LOAD = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic              state_reg;
    logic              state_next;
    count_t            count_reg;
    count_t            count_next;
    sample_t           min_reg;
    sample_t           min_next;
    sample_t           max_reg;
    sample_t           max_next;
    sum_t              sum_reg;
    sum_t              sum_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic [SHIFT_W-1:0] shift_cnt_reg;
    logic [SHIFT_W-1:0] shift_cnt_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    sample_t           m_min_reg;
    sample_t           m_max_reg;
    sample_t           m_mean_reg;
    logic [MEDIAN_W-1:0] m_median_reg;
    count_t            m_count_reg;
    logic              m_overflow_reg;

    logic              accept;
    logic              has_room;
    logic              store;
    logic [SHIFT_W-1:0] shift_target;
    logic              shifting;
    logic              finished;
    logic              deliver;
    logic              div_start;
    logic              div_done;
    sum_t              div_quotient;
    logic [MEDIAN_W-1:0] median_sum;
    ssstat_cell_ctrl_t cell_ctrl;

    sample_t           cell_value [MAX_SAMPLES];
    logic              cell_stays [MAX_SAMPLES];

    assign s_ready  = (state_reg == S_LOAD);
    assign accept   = s_valid && s_ready;
    assign has_room = (count_reg != COUNT_W'(MAX_SAMPLES));
    assign store    = accept && has_room;

    // For an even count the two middle samples end in the first two cells.
    assign shift_target = count_reg[COUNT_W-1:1] - {{(SHIFT_W-1){1'b0}}, !count_reg[0]};
    assign shifting     = (state_reg == S_CALC) && (shift_cnt_reg != shift_target);
    assign finished     = (state_reg == S_CALC) && !shifting && div_done;
    assign deliver      = finished && (!m_valid_reg || m_ready);

    assign cell_ctrl.insert = store;
    assign cell_ctrl.shift  = shifting;

    assign median_sum = {1'b0, cell_value[0]}
                      + {1'b0, (count_reg[0] ? cell_value[0] : cell_value[1])};

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        dropped_next   = dropped_reg;
        shift_cnt_next = shift_cnt_reg;
        div_start      = 1'b0;
        case (state_reg)
            S_LOAD: begin
                if (store) begin
                    count_next = count_reg + 1'b1;
                    min_next   = (s_sample < min_reg) ? s_sample : min_reg;
                    max_next   = (s_sample > max_reg) ? s_sample : max_reg;
                    sum_next   = sum_reg + SUM_W'(s_sample);
                end else if (accept) begin
                    dropped_next = 1'b1;
                end
                if (accept && s_last) begin
                    state_next     = S_CALC;
                    shift_cnt_next = '0;
                    div_start      = 1'b1;
                end
            end
            S_CALC: begin
                if (shifting) begin
                    shift_cnt_next = shift_cnt_reg + 1'b1;
                end
                if (deliver) begin
                    state_next   = S_LOAD;
                    count_next   = '0;
                    min_next     = '1;
                    max_next     = '0;
                    sum_next     = '0;
                    dropped_next = 1'b0;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (deliver) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            sum_reg       <= '0;
            dropped_reg   <= 1'b0;
            shift_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            dropped_reg   <= dropped_next;
            shift_cnt_reg <= shift_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (deliver) begin
            m_min_reg      <= min_reg;
            m_max_reg      <= max_reg;
            m_mean_reg     <= div_quotient[SAMPLE_BITS-1:0];
            m_median_reg   <= median_sum;
            m_count_reg    <= count_reg;
            m_overflow_reg <= dropped_reg;
        end
    end

    // The divider starts on the edge that takes the last word, from the updated totals.
    ssstat_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
        sample_t left_value;
        logic    left_stays;
        sample_t right_value;

        if (i == 0) begin : g_head
            assign left_value = s_sample;
            assign left_stays = 1'b1;
        end else begin : g_body
            assign left_value = cell_value[i-1];
            assign left_stays = cell_stays[i-1];
        end

        if (i == MAX_SAMPLES - 1) begin : g_tail
            assign right_value = '0;
        end else begin : g_inner
            assign right_value = cell_value[i+1];
        end

        ssstat_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl),
            .new_sample  (s_sample),
            .occupied    (count_reg > COUNT_W'(i)),
            .left_value  (left_value),
            .left_stays  (left_stays),
            .right_value (right_value),
            .value       (cell_value[i]),
            .stays       (cell_stays[i])
        );
    end

    assign m_valid          = m_valid_reg;
    assign m_minimum        = m_min_reg;
    assign m_maximum        = m_max_reg;
    assign m_mean           = m_mean_reg;
    assign m_median_doubled = m_median_reg;
    assign m_sample_count   = m_count_reg;
    assign m_overflow       = m_overflow_reg;

endmodule

### sv/ssstat_cell.sv
// One cell of the sorting chain: holds one sample in ascending order.
module ssstat_cell (
    input  logic                          aclk,
    input  ssstat_pkg::ssstat_cell_ctrl_t ctrl,
    input  ssstat_pkg::sample_t           new_sample,
    input  logic                          occupied,
    input  ssstat_pkg::sample_t           left_value,
    input  logic                          left_stays,
    input  ssstat_pkg::sample_t           right_value,
    output ssstat_pkg::sample_t           value,
    output logic                          stays
);
    import ssstat_pkg::*;

    sample_t value_reg;
    sample_t value_next;

    // A cell keeps its sample when it is occupied and not larger than the new one.
    assign stays = occupied && (value_reg <= new_sample);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.insert && !stays) begin
            value_next = left_stays ? new_sample : left_value;
        end else if (ctrl.shift) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

### sv/ssstat_divider.sv
// Restoring divider, one quotient bit per cycle, for the floor mean.
module ssstat_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  ssstat_pkg::sum_t     dividend,
    input  ssstat_pkg::count_t   divisor,
    output logic                 done,
    output ssstat_pkg::sum_t     quotient
);
    import ssstat_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    sum_t              quo_reg;
    sum_t              quo_next;
    count_t            rem_reg;
    count_t            rem_next;
    count_t            div_reg;
    count_t            div_next;
    logic [COUNT_W:0]  rem_shift;
    logic [COUNT_W:0]  rem_diff;
    logic              fits;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_comb begin
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            step_next = STEP_W'(SUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (step_reg != '0) begin
            step_next = step_reg - 1'b1;
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = (step_reg == '0);
    assign quotient = quo_reg;

endmodule
